>>> rtl/hrfc_pkg.sv
// ----------------------------------------------------------------------------
// hrfc_pkg
// Shared types, constants and the FNV-1a step for the record frame checker.
// ----------------------------------------------------------------------------
package hrfc_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned MONTH_W   = 8;
  localparam int unsigned DAY_W     = 8;
  localparam int unsigned CLEN_W    = 21;
  localparam int unsigned HASH_W    = 64;
  localparam int unsigned WORD_W    = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_MAGIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 1'b1;

  localparam logic [CLEN_W-1:0] MAX_LENGTH_RESET = 21'd1048576;

  // Default width of the content byte counter
  localparam int unsigned LENGTH_COUNT_WIDTH_DEF = 21;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_FILE_MAGIC  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ENTRY_MAGIC = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LENGTH      = 2'd2;
  localparam logic [ERR_W-1:0] ERR_CHECK       = 2'd3;

  // Hash constants
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] TAG_CONST = 64'h4B6C65654B6C6565;

  // Magic sequences, first byte in the low byte
  localparam logic [63:0] FILE_MAGIC  = 64'h2161_7969_6D69_6F59;
  localparam logic [31:0] ENTRY_MAGIC = 32'h6565_6C4B;

  // One result transaction
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  content_byte;
    logic [ERR_W-1:0]   error_code;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [CLEN_W-1:0]  frame_length;
  } result_t;

  // One FNV-1a step: xor the sign-extended byte, multiply by 2^40 + 0x1b3
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [DATA_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-DATA_W){b[DATA_W-1]}}, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

>>> rtl/hashed_record_frame_checker_core.sv
// ----------------------------------------------------------------------------
// hashed_record_frame_checker_core
// Byte-stream checker for hashed record frames with content pass-through.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_ready is high, with no gaps
// needed between bytes. Each byte passes through the frame parser and a
// 64-bit FNV-1a update (xor plus a shift-add multiply by the sparse prime),
// the longest path, which sets the one-byte-per-cycle rate. Each result is
// registered into the main output slot, or into the skid slot when the main
// slot is stalled; in_ready drops only when both entries are full, so bytes
// keep flowing while one result waits. Configuration writes are taken in any
// cycle (cfg_ready is tied high) and must be made while the block is idle.
module hashed_record_frame_checker_core #(
  parameter int unsigned LENGTH_COUNT_WIDTH = hrfc_pkg::LENGTH_COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input byte stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hrfc_pkg::DATA_W-1:0]       in_data_byte,
  // Results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hrfc_pkg::KIND_W-1:0]       out_result_kind,
  output logic [hrfc_pkg::DATA_W-1:0]       out_content_byte,
  output logic [hrfc_pkg::ERR_W-1:0]        out_error_code,
  output logic [hrfc_pkg::YEAR_W-1:0]       out_year,
  output logic [hrfc_pkg::MONTH_W-1:0]      out_month,
  output logic [hrfc_pkg::DAY_W-1:0]        out_day,
  output logic [hrfc_pkg::CLEN_W-1:0]       out_frame_length,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hrfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hrfc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned LW = LENGTH_COUNT_WIDTH;
  localparam logic [32:0] LEN_CAP = (33'd1 << LW) - 33'd1;

  typedef enum logic [6:0] {
    PH_FILE  = 7'b0000001,
    PH_ENTRY = 7'b0000010,
    PH_HASH  = 7'b0000100,
    PH_DATE  = 7'b0001000,
    PH_LEN   = 7'b0010000,
    PH_BODY  = 7'b0100000,
    PH_TAIL  = 7'b1000000
  } phase_t;

  // Configuration registers
  logic                           req_magic_r;
  logic [hrfc_pkg::CLEN_W-1:0]    max_len_r;

  // Parser state
  phase_t                         phase_r, phase_nxt;
  logic [2:0]                     idx_r, idx_nxt;
  logic [hrfc_pkg::HASH_W-1:0]    hash_r, hash_nxt;
  logic [hrfc_pkg::HASH_W-1:0]    stored_r, stored_nxt;
  logic [hrfc_pkg::WORD_W-1:0]    date_r, date_nxt;
  logic [23:0]                    len_lo_r, len_lo_nxt;
  logic [hrfc_pkg::CLEN_W-1:0]    len_r, len_nxt;
  logic [LW-1:0]                  rem_r, rem_nxt;
  logic [hrfc_pkg::HASH_W-1:0]    tag_r, tag_nxt;

  // Output buffer
  logic                           out_valid_r, skid_valid_r;
  hrfc_pkg::result_t              out_r, skid_r;

  logic                           in_fire, push, pop;
  hrfc_pkg::result_t              res;
  logic                           has_res;
  phase_t                         eff_phase;
  logic [hrfc_pkg::WORD_W-1:0]    len_full;
  logic [hrfc_pkg::HASH_W-1:0]    tag_full;
  logic [hrfc_pkg::HASH_W-1:0]    hash_upd;
  logic                           len_over;
  logic                           frame_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign push      = in_fire && has_res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_magic_r <= 1'b1;
      max_len_r   <= hrfc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hrfc_pkg::CFG_REQUIRE_MAGIC: req_magic_r <= cfg_data[0];
        hrfc_pkg::CFG_MAX_LENGTH:    max_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath helpers
  assign hash_upd = hrfc_pkg::fnv_step(hash_r, in_data_byte);
  assign len_full = {in_data_byte, len_lo_r};
  assign tag_full = {in_data_byte, tag_r[hrfc_pkg::HASH_W-1:8]};
  assign len_over = (len_full > {11'd0, max_len_r}) || ({1'b0, len_full} > LEN_CAP);
  assign frame_ok = (stored_r == hash_r) && (tag_full == (hrfc_pkg::TAG_CONST ^ hash_r));

  // Skip the file magic when it is not required and none has been taken
  always_comb begin
    eff_phase = phase_r;
    if (phase_r == PH_FILE && idx_r == 3'd0 && !req_magic_r) begin
      eff_phase = PH_ENTRY;
    end
  end

  // Parse one byte
  always_comb begin
    phase_nxt  = eff_phase;
    idx_nxt    = idx_r + 3'd1;
    hash_nxt   = hash_r;
    stored_nxt = stored_r;
    date_nxt   = date_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    tag_nxt    = tag_r;
    has_res    = 1'b0;
    res        = '0;

    unique case (eff_phase)
      PH_FILE: begin
        if (in_data_byte != hrfc_pkg::FILE_MAGIC[idx_r*8 +: 8]) begin
          has_res        = 1'b1;
          res.kind       = hrfc_pkg::KIND_ERROR;
          res.error_code = hrfc_pkg::ERR_FILE_MAGIC;
          phase_nxt      = PH_ENTRY;
          idx_nxt        = 3'd0;
        end else if (idx_r == 3'd7) begin
          phase_nxt = PH_ENTRY;
          idx_nxt   = 3'd0;
        end
      end
      PH_ENTRY: begin
        if (in_data_byte != hrfc_pkg::ENTRY_MAGIC[idx_r[1:0]*8 +: 8]) begin
          has_res        = 1'b1;
          res.kind       = hrfc_pkg::KIND_ERROR;
          res.error_code = hrfc_pkg::ERR_ENTRY_MAGIC;
          idx_nxt        = 3'd0;
        end else if (idx_r == 3'd3) begin
          phase_nxt = PH_HASH;
          idx_nxt   = 3'd0;
        end
      end
      PH_HASH: begin
        stored_nxt = {in_data_byte, stored_r[hrfc_pkg::HASH_W-1:8]};
        if (idx_r == 3'd7) begin
          phase_nxt = PH_DATE;
          idx_nxt   = 3'd0;
        end
      end
      PH_DATE: begin
        hash_nxt = hash_upd;
        date_nxt = {in_data_byte, date_r[hrfc_pkg::WORD_W-1:8]};
        if (idx_r == 3'd3) begin
          phase_nxt = PH_LEN;
          idx_nxt   = 3'd0;
        end
      end
      PH_LEN: begin
        hash_nxt   = hash_upd;
        len_lo_nxt = {in_data_byte, len_lo_r[23:8]};
        if (idx_r == 3'd3) begin
          idx_nxt = 3'd0;
          len_nxt = len_full[hrfc_pkg::CLEN_W-1:0];
          rem_nxt = len_full[LW-1:0];
          if (len_over) begin
            has_res        = 1'b1;
            res.kind       = hrfc_pkg::KIND_ERROR;
            res.error_code = hrfc_pkg::ERR_LENGTH;
            phase_nxt      = PH_ENTRY;
          end else if (len_full == '0) begin
            phase_nxt = PH_TAIL;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        hash_nxt         = hash_upd;
        rem_nxt          = rem_r - LW'(1);
        idx_nxt          = 3'd0;
        has_res          = 1'b1;
        res.kind         = hrfc_pkg::KIND_CONTENT;
        res.content_byte = in_data_byte;
        if (rem_r == LW'(1)) begin
          phase_nxt = PH_TAIL;
        end
      end
      PH_TAIL: begin
        tag_nxt = tag_full;
        if (idx_r == 3'd7) begin
          has_res   = 1'b1;
          phase_nxt = PH_ENTRY;
          idx_nxt   = 3'd0;
          if (frame_ok) begin
            res.kind         = hrfc_pkg::KIND_FRAME;
            res.year         = date_r[31:16];
            res.month        = date_r[15:8];
            res.day          = date_r[7:0];
            res.frame_length = len_r;
          end else begin
            res.kind       = hrfc_pkg::KIND_ERROR;
            res.error_code = hrfc_pkg::ERR_CHECK;
          end
        end
      end
      default: begin
        phase_nxt = PH_ENTRY;
        idx_nxt   = 3'd0;
      end
    endcase

    // Restart the hash for the next frame
    if (phase_nxt == PH_ENTRY && idx_nxt == 3'd0) begin
      hash_nxt = hrfc_pkg::FNV_BASIS;
    end
  end

  // Advance parser control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      idx_r   <= 3'd0;
      hash_r  <= hrfc_pkg::FNV_BASIS;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // Hold frame fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stored_r <= stored_nxt;
      date_r   <= date_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      tag_r    <= tag_nxt;
    end
  end

  // Output buffer control: main slot plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_r.kind;
  assign out_content_byte   = out_r.content_byte;
  assign out_error_code     = out_r.error_code;
  assign out_year           = out_r.year;
  assign out_month          = out_r.month;
  assign out_day            = out_r.day;
  assign out_frame_length   = out_r.frame_length;

endmodule

>>> rtl/hrfc_checker.sv
// ----------------------------------------------------------------------------
// hrfc_checker
// Port-level checks for the record frame checker, bound to its top level.
// ----------------------------------------------------------------------------
module hrfc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [hrfc_pkg::KIND_W-1:0]       out_result_kind,
  input logic [hrfc_pkg::DATA_W-1:0]       out_content_byte,
  input logic [hrfc_pkg::ERR_W-1:0]        out_error_code,
  input logic [hrfc_pkg::YEAR_W-1:0]       out_year,
  input logic [hrfc_pkg::CLEN_W-1:0]       out_frame_length
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
                                $stable(out_content_byte))
    else $error("result transaction changed while stalled");

  // Drop output valid after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Only the three defined result kinds leave the block
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind == hrfc_pkg::KIND_CONTENT ||
                  out_result_kind == hrfc_pkg::KIND_FRAME ||
                  out_result_kind == hrfc_pkg::KIND_ERROR)
    else $error("undefined result kind");

  // Accepted frames carry no content byte and no error code
  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == hrfc_pkg::KIND_FRAME |->
      out_content_byte == '0 && out_error_code == '0)
    else $error("frame result carries stray fields");

  // Errors and content bytes carry no frame summary
  a_no_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != hrfc_pkg::KIND_FRAME |->
      out_year == '0 && out_frame_length == '0)
    else $error("frame summary outside a frame result");

endmodule

bind hashed_record_frame_checker_core hrfc_checker u_hrfc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_content_byte   (out_content_byte),
  .out_error_code     (out_error_code),
  .out_year           (out_year),
  .out_frame_length   (out_frame_length)
);

>>> bench/frame_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// frame_scoreboard_pkg
// Scoreboard for the record frame checker: a byte-level frame parser that
// predicts each result, and a checker that compares results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package frame_scoreboard_pkg;

  import hrfc_pkg::*;

  localparam logic [63:0] FNV_MULT   = 64'h0000_0100_0000_01B3;
  localparam logic [31:0] COUNT_CAP  = (32'd1 << LENGTH_COUNT_WIDTH_DEF) - 32'd1;

  typedef enum logic [2:0] {
    SCAN_FILE_MAGIC,
    SCAN_ENTRY_MAGIC,
    SCAN_STORED_HASH,
    SCAN_DATE,
    SCAN_LENGTH,
    SCAN_CONTENT,
    SCAN_END_TAG
  } frame_phase_t;

  // Fold one byte into a 64-bit FNV-1a hash, byte sign-extended first
  function automatic logic [63:0] fnv1a_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {{56{b[7]}}, b};
    return x * FNV_MULT;
  endfunction

  class frame_scoreboard;
    // Mirrored configuration
    bit          magic_on;
    logic [20:0] length_limit;

    // Parser state
    frame_phase_t phase;
    int unsigned  field_count;
    logic [63:0]  stored_hash;
    logic [63:0]  running_hash;
    logic [31:0]  date_word;
    logic [31:0]  length_word;
    logic [63:0]  end_tag;

    result_t     pending_results[$];
    int unsigned mismatches;

    function new();
      magic_on     = 1'b1;
      length_limit = MAX_LENGTH_RESET;
      mismatches   = 0;
      restart_frame();
      phase = SCAN_FILE_MAGIC;
    endfunction

    function void restart_frame();
      phase        = SCAN_ENTRY_MAGIC;
      field_count  = 0;
      stored_hash  = '0;
      running_hash = FNV_BASIS;
      date_word    = '0;
      length_word  = '0;
      end_tag      = '0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_REQUIRE_MAGIC) magic_on = value[0];
      else if (idx == CFG_MAX_LENGTH) length_limit = value;
    endfunction

    function void raise_error(input logic [ERR_W-1:0] code);
      result_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      pending_results = {pending_results, r};
      restart_frame();
    endfunction

    // Advance the parser by one accepted byte and queue any result it causes
    function void take_byte(input logic [7:0] b);
      int unsigned n;
      result_t r;
      n = field_count;
      r = '0;
      // Skip the file magic when it is switched off and none has been taken
      if (phase == SCAN_FILE_MAGIC && n == 0 && !magic_on) phase = SCAN_ENTRY_MAGIC;
      case (phase)
        SCAN_FILE_MAGIC: begin
          if (b != FILE_MAGIC[8*(n%8) +: 8]) raise_error(ERR_FILE_MAGIC);
          else if (n >= 7) restart_frame();
          else field_count = n + 1;
        end
        SCAN_ENTRY_MAGIC: begin
          if (b != ENTRY_MAGIC[8*(n%4) +: 8]) raise_error(ERR_ENTRY_MAGIC);
          else if (n >= 3) begin
            phase = SCAN_STORED_HASH;
            field_count = 0;
          end else field_count = n + 1;
        end
        SCAN_STORED_HASH: begin
          stored_hash[8*(n%8) +: 8] = b;
          field_count = n + 1;
          if (n >= 7) begin
            phase = SCAN_DATE;
            field_count = 0;
          end
        end
        SCAN_DATE: begin
          running_hash = fnv1a_mix(running_hash, b);
          date_word[8*(n%4) +: 8] = b;
          field_count = n + 1;
          if (n >= 3) begin
            phase = SCAN_LENGTH;
            field_count = 0;
          end
        end
        SCAN_LENGTH: begin
          running_hash = fnv1a_mix(running_hash, b);
          length_word[8*(n%4) +: 8] = b;
          field_count = n + 1;
          if (n >= 3) begin
            if (length_word > {11'd0, length_limit} || length_word > COUNT_CAP) begin
              raise_error(ERR_LENGTH);
            end else begin
              field_count = 0;
              phase = (length_word == 0) ? SCAN_END_TAG : SCAN_CONTENT;
            end
          end
        end
        SCAN_CONTENT: begin
          running_hash = fnv1a_mix(running_hash, b);
          field_count = n + 1;
          if (field_count >= length_word) begin
            phase = SCAN_END_TAG;
            field_count = 0;
          end
          r.kind = KIND_CONTENT;
          r.content_byte = b;
          pending_results = {pending_results, r};
        end
        SCAN_END_TAG: begin
          end_tag[8*(n%8) +: 8] = b;
          field_count = n + 1;
          if (n >= 7) begin
            if (stored_hash == running_hash && end_tag == (TAG_CONST ^ running_hash)) begin
              r.kind = KIND_FRAME;
              r.year = date_word[31:16];
              r.month = date_word[15:8];
              r.day = date_word[7:0];
              r.frame_length = length_word[20:0];
              pending_results = {pending_results, r};
              restart_frame();
            end else raise_error(ERR_CHECK);
          end
        end
        default: restart_frame();
      endcase
    endfunction

    function void compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result transaction against the oldest prediction
    function void check_result(input result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: expected no result, got kind %0h byte %0h error %0h",
                 $time, got.kind, got.content_byte, got.error_code);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("content_byte", want.content_byte, got.content_byte);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void report_leftover();
      if (pending_results.size() != 0) begin
        $display("%0t: expected %0d more results, got none", $time, pending_results.size());
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream test of the record frame checker: builds good and broken frames,
// feeds them in bursts under random output stalls, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import hrfc_pkg::*;
  import frame_scoreboard_pkg::*;

  localparam time RUN_LIMIT = 3_000_000;

  typedef enum int {FR_GOOD, FR_BAD_HASH, FR_BAD_TAG, FR_TOO_LONG} frame_flavor_t;

  // Stream openings
  localparam int START_NO_MAGIC    = 0;
  localparam int START_SPLIT_MAGIC = 1;
  localparam int START_BAD_MAGIC   = 2;

  // Receiver stall patterns
  localparam int RX_STEADY = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;
  localparam int RX_TOGGLE = 3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DATA_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     out_result_kind;
  logic [DATA_W-1:0]     out_content_byte;
  logic [ERR_W-1:0]      out_error_code;
  logic [YEAR_W-1:0]     out_year;
  logic [MONTH_W-1:0]    out_month;
  logic [DAY_W-1:0]      out_day;
  logic [CLEN_W-1:0]     out_frame_length;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  logic [7:0]      stream_bytes[$];
  int              stall_requests = 0;
  int              stall_served = 0;
  int              hold_left = 0;
  int              recv_mode = RX_STEADY;
  int              mode_left = 0;
  logic            ready_next;

  hashed_record_frame_checker_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_content_byte   (out_content_byte),
    .out_error_code     (out_error_code),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_frame_length   (out_frame_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #6 clk = ~clk;

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_result_kind, out_content_byte, out_error_code, out_year,
                       out_month, out_day, out_frame_length});
    end
  end

  // Stall the receiver on a changing pattern; hold off long when asked
  always @(negedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      hold_left = 120;
    end
    if (mode_left == 0) begin
      recv_mode = $urandom_range(RX_STEADY, RX_TOGGLE);
      mode_left = $urandom_range(20, 150);
    end else mode_left--;
    case (recv_mode)
      RX_STEADY: ready_next = 1'b1;
      RX_LIGHT:  ready_next = ($urandom_range(0, 3) != 0);
      RX_HEAVY:  ready_next = ($urandom_range(0, 9) < 3);
      default:   ready_next = ~out_ready;
    endcase
    if (hold_left > 0) begin
      ready_next = 1'b0;
      hold_left--;
    end
    out_ready <= ready_next;
  end

  // Append count bytes of value, low byte first
  task automatic push_bytes(input logic [63:0] value, input int count);
    int i;
    for (i = 0; i < count; i++) stream_bytes = {stream_bytes, value[8*i +: 8]};
  endtask

  // Append one frame; walk fills the content with 00 7F 80 FF in turn
  task automatic add_frame(input frame_flavor_t flavor, input logic [31:0] date,
                           input logic [31:0] len, input bit walk);
    logic [63:0] h;
    logic [63:0] stored;
    logic [63:0] tag;
    logic [7:0]  c;
    logic [7:0]  body[$];
    int          i;
    h = FNV_BASIS;
    for (i = 0; i < 4; i++) h = fnv1a_mix(h, date[8*i +: 8]);
    for (i = 0; i < 4; i++) h = fnv1a_mix(h, len[8*i +: 8]);
    if (flavor != FR_TOO_LONG) begin
      for (i = 0; i < len; i++) begin
        case (i % 4)
          0: c = walk ? 8'h00 : 8'($urandom);
          1: c = walk ? 8'h7F : 8'($urandom);
          2: c = walk ? 8'h80 : 8'($urandom);
          default: c = walk ? 8'hFF : 8'($urandom);
        endcase
        body = {body, c};
        h = fnv1a_mix(h, c);
      end
    end
    stored = h;
    tag = TAG_CONST ^ h;
    case (flavor)
      FR_BAD_HASH: stored = h ^ ({$urandom, $urandom} | 64'h1);
      FR_BAD_TAG:  tag = tag ^ (64'h1 << $urandom_range(0, 63));
      FR_TOO_LONG: stored = {$urandom, $urandom};
      default: ;
    endcase
    push_bytes({32'd0, ENTRY_MAGIC}, 4);
    push_bytes(stored, 8);
    push_bytes({32'd0, date}, 4);
    push_bytes({32'd0, len}, 4);
    if (flavor != FR_TOO_LONG) begin
      foreach (body[i]) stream_bytes = {stream_bytes, body[i]};
      push_bytes(tag, 8);
    end
  endtask

  // Append an entry magic that breaks at byte pos
  task automatic add_broken_magic(input int pos);
    logic [7:0] wrong;
    push_bytes({32'd0, ENTRY_MAGIC}, pos);
    wrong = 8'($urandom);
    if (wrong == ENTRY_MAGIC[8*pos +: 8]) wrong = ~wrong;
    stream_bytes = {stream_bytes, wrong};
  endtask

  function automatic logic [31:0] pick_length(input logic [20:0] limit);
    int top;
    top = (limit < 24) ? limit : 24;
    if ($urandom_range(0, 19) == 0) top = (limit < 200) ? limit : 200;
    return $urandom_range(0, top);
  endfunction

  function automatic logic [31:0] pick_oversize(input logic [20:0] limit);
    case ($urandom_range(0, 3))
      0: return {11'd0, limit} + 32'd1;
      1: return {11'd0, limit} + 32'd1 + $urandom_range(0, 5000);
      2: return $urandom | 32'h8000_0000;
      default: return 32'h0020_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  // Append a random item: mostly good frames, the rest broken frames and noise
  task automatic add_random_item(input logic [20:0] limit);
    int         sel;
    int         i;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 62) add_frame(FR_GOOD, $urandom, pick_length(limit), 1'b0);
    else if (sel < 70) add_frame(FR_BAD_HASH, $urandom, pick_length(limit), 1'b0);
    else if (sel < 78) add_frame(FR_BAD_TAG, $urandom, pick_length(limit), 1'b0);
    else if (sel < 86) add_broken_magic($urandom_range(0, 3));
    else if (sel < 92) add_frame(FR_TOO_LONG, $urandom, pick_oversize(limit), 1'b0);
    else begin
      // keep noise from starting a magic so following frames stay aligned
      for (i = 0; i < $urandom_range(1, 4); i++) begin
        b = 8'($urandom);
        if (b == ENTRY_MAGIC[7:0]) b = ~b;
        stream_bytes = {stream_bytes, b};
      end
    end
  endtask

  // Offer the queued bytes in bursts with random gaps
  task automatic play_stream();
    int         burst;
    int         gap;
    logic [7:0] b;
    burst = 0;
    while (stream_bytes.size() > 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      b = stream_bytes.pop_front();
      @(negedge clk);
      in_valid <= 1'b1;
      in_data_byte <= b;
      do @(posedge clk); while (!in_ready);
      sb.take_byte(b);
      burst--;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for all predicted results, then let the pipeline empty
  task automatic settle();
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input bit magic_on, input logic [20:0] limit,
                                  input int nbytes, input bit squeeze);
    write_register(CFG_REQUIRE_MAGIC, {20'd0, magic_on});
    write_register(CFG_MAX_LENGTH, limit);
    if (squeeze) begin
      // long frame under a receiver hold-off fills the output buffer
      add_frame(FR_GOOD, $urandom, (limit < 100) ? limit : 100, 1'b0);
      stall_requests++;
    end
    while (stream_bytes.size() < nbytes) add_random_item(limit);
    play_stream();
    settle();
  endtask

  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_flow
    int         start_mode;
    int         split;
    int         i;
    int         waited;
    logic [7:0] wrong;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Open the stream one of three ways
    start_mode = $urandom_range(START_NO_MAGIC, START_BAD_MAGIC);
    case (start_mode)
      START_NO_MAGIC: write_register(CFG_REQUIRE_MAGIC, '0);
      START_SPLIT_MAGIC: begin
        // switching the magic off mid-check must not stop it
        split = $urandom_range(1, 7);
        push_bytes(FILE_MAGIC, split);
        play_stream();
        settle();
        write_register(CFG_REQUIRE_MAGIC, '0);
        for (i = split; i < 8; i++) stream_bytes = {stream_bytes, FILE_MAGIC[8*i +: 8]};
      end
      default: begin
        split = $urandom_range(0, 7);
        push_bytes(FILE_MAGIC, split);
        wrong = 8'($urandom);
        if (wrong == FILE_MAGIC[8*split +: 8]) wrong = ~wrong;
        stream_bytes = {stream_bytes, wrong};
      end
    endcase

    // Directed frames: extremes, sign extension, each error
    add_frame(FR_GOOD, 32'h0000_0000, 32'd0, 1'b0);
    add_frame(FR_GOOD, 32'hFFFF_FFFF, 32'd4, 1'b1);
    add_frame(FR_GOOD, $urandom, 32'd1, 1'b0);
    add_broken_magic(0);
    add_broken_magic(3);
    add_frame(FR_BAD_HASH, $urandom, 32'd2, 1'b0);
    add_frame(FR_BAD_TAG, $urandom, 32'd0, 1'b0);
    add_frame(FR_TOO_LONG, $urandom, 32'hFFFF_FFFF, 1'b0);
    add_frame(FR_TOO_LONG, $urandom, 32'd1048577, 1'b0);
    add_frame(FR_GOOD, $urandom, 32'd3, 1'b0);
    play_stream();
    settle();

    // Zero length limit: only empty frames pass
    add_frame(FR_GOOD, $urandom, 32'd0, 1'b0);
    add_frame(FR_TOO_LONG, $urandom, 32'd1, 1'b0);
    run_random_phase(1'b0, 21'd0, 60, 1'b0);

    // Reset length limit with a long hold-off
    run_random_phase(1'b1, MAX_LENGTH_RESET, 120, 1'b1);

    // Random settings
    run_random_phase($urandom_range(0, 1), 21'($urandom_range(1, 64)), 40, 1'b0);
    run_random_phase($urandom_range(0, 1), MAX_LENGTH_RESET, 120, 1'b1);
    run_random_phase($urandom_range(0, 1), 21'($urandom_range(0, 1048576)), 40, 1'b0);
    run_random_phase($urandom_range(0, 1), 21'($urandom_range(1, 300)), 40, 1'b0);

    waited = 0;
    while (sb.pending_count() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    sb.report_leftover();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
